@@ rtl/shcc_pkg.sv @@
// ----------------------------------------------------------------------------
// shcc_pkg: shared types and constants for strip hit selection
// Widths of the item fields, register codes, sequencer states and the small
// structs passed between the map scan and the top-level control.
// ----------------------------------------------------------------------------
package shcc_pkg;

  // Default geometry
  localparam int DETECTORS_DEF = 16;
  localparam int STRIPS_DEF    = 256;

  // Map word, one memory entry
  localparam int MAP_WORD_W = 64;

  // Detector numbering: tile + 8 * (layer - 55)
  localparam logic [7:0] LAYER_BASE = 8'd55;

  // Detectors counted as phi; the rest are z
  localparam int PHI_DETS = 8;

  // Results per event at most
  localparam int MAX_RESULTS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [9:0] WINDOW_LOW_RST     = 10'd20;
  localparam logic [9:0] WINDOW_HIGH_RST    = 10'd45;
  localparam logic [7:0] SIGMA_MULTIPLE_RST = 8'd80;  // 5.0 in sixteenths

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW     = 2'd0,
    CFG_WINDOW_HIGH    = 2'd1,
    CFG_SIGMA_MULTIPLE = 2'd2
  } cfg_index_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_UPDATE = 3'd2,
    ST_SCAN   = 3'd3,
    ST_DRAIN  = 3'd4,
    ST_EMIT   = 3'd5
  } state_e;

  // Outcome of the hit test
  typedef struct packed {
    logic signal;
    logic mapped;
  } hit_flags_t;

  // Tag travelling with a map word read during the scan
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } scan_tag_t;

  // Per-detector completion from the run counter
  typedef struct packed {
    logic valid;
    logic last;
  } cnt_done_t;

  // Event cluster totals
  typedef struct packed {
    logic [15:0] total;
    logic [15:0] phi;
    logic [15:0] z;
  } cluster_sums_t;

  // 16-bit add that sticks at all ones
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

@@ rtl/shcc_hit_test.sv @@
// ----------------------------------------------------------------------------
// shcc_hit_test: signal test and map addressing of one waveform
// Applies the window and threshold test (pedestal and noise in 1/16 ADC, peak in ADC counts,
// compare in 1/256 ADC) and works out the map word and bit of the strip.
// ----------------------------------------------------------------------------
module shcc_hit_test #(
  parameter int DETECTORS = shcc_pkg::DETECTORS_DEF,
  parameter int STRIPS    = shcc_pkg::STRIPS_DEF
) (
  input  logic [9:0]                                          window_low_i,
  input  logic [9:0]                                          window_high_i,
  input  logic [7:0]                                          sigma_multiple_i,
  input  logic [7:0]                                          layer_id_i,
  input  logic [2:0]                                          tile_id_i,
  input  logic [7:0]                                          strip_id_i,
  input  logic [9:0]                                          peak_adc_i,
  input  logic [9:0]                                          peak_sample_i,
  input  logic [13:0]                                         pedestal_level_i,
  input  logic [13:0]                                         noise_rms_i,
  output shcc_pkg::hit_flags_t                                flags_o,
  output logic [$clog2(DETECTORS*((STRIPS+63)/64))-1:0]       addr_o,
  output logic [5:0]                                          bit_o
);
  import shcc_pkg::*;

  localparam int WPD   = (STRIPS + 63) / 64;
  localparam int DEPTH = DETECTORS * WPD;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]  layer_diff;
  logic [10:0] det_num;
  logic        det_ok;
  logic [21:0] noise_term;
  logic [22:0] threshold;
  logic [22:0] peak_scaled;
  logic        in_window;

  // Detector number; layers below the base wrap around and are not mapped
  assign layer_diff = layer_id_i - LAYER_BASE;
  assign det_num    = {layer_diff, tile_id_i};
  assign det_ok     = (layer_id_i >= LAYER_BASE) && (int'(det_num) < DETECTORS);

  // Threshold: pedestal*16 + sigma*rms against peak*256
  assign noise_term  = 22'(sigma_multiple_i) * 22'(noise_rms_i);
  assign threshold   = 23'({pedestal_level_i, 4'b0000}) + 23'(noise_term);
  assign peak_scaled = 23'({peak_adc_i, 8'h00});

  assign in_window = (peak_sample_i >= window_low_i) && (peak_sample_i < window_high_i);

  // Unused channels never count as signal
  assign flags_o.signal = (layer_id_i != 8'd0) && (noise_rms_i != 14'd0) && in_window &&
                          (peak_scaled > threshold);
  assign flags_o.mapped = det_ok && (int'(strip_id_i) < STRIPS);

  // Row per detector, WPD words per row
  assign addr_o = AW'(int'(det_num) * WPD + int'(strip_id_i[7:6]));
  assign bit_o  = strip_id_i[5:0];

endmodule

@@ rtl/shcc_map_mem.sv @@
// ----------------------------------------------------------------------------
// shcc_map_mem: strip occupancy memory
// One write and one read per cycle, registered read data. A read and a write
// to the same word in one cycle return the old contents.
// ----------------------------------------------------------------------------
module shcc_map_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic [shcc_pkg::MAP_WORD_W-1:0] wdata_i,
  input  logic                            re_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic [shcc_pkg::MAP_WORD_W-1:0] rdata_o
);
  import shcc_pkg::*;

  logic [MAP_WORD_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/shcc_run_count.sv @@
// ----------------------------------------------------------------------------
// shcc_run_count: cluster counting over the scanned map words
// Stage one marks rising edges of each word (carrying the last strip of the
// previous word) and counts them in two halves; stage two accumulates per
// detector and folds finished detectors into the event totals.
// ----------------------------------------------------------------------------
module shcc_run_count #(
  parameter int DETECTORS = shcc_pkg::DETECTORS_DEF,
  parameter int STRIPS    = shcc_pkg::STRIPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  shcc_pkg::scan_tag_t                 tag_i,
  input  logic [shcc_pkg::MAP_WORD_W-1:0]     word_i,
  output shcc_pkg::cnt_done_t                 done_o,
  output logic [$clog2(DETECTORS)-1:0]        det_o,
  output logic [$clog2(STRIPS/2+1)-1:0]       count_o,
  output shcc_pkg::cluster_sums_t             sums_o
);
  import shcc_pkg::*;

  localparam int DW    = $clog2(DETECTORS);
  localparam int CNT_W = $clog2(STRIPS / 2 + 1);
  localparam int HALF  = MAP_WORD_W / 2;

  logic                  prev;
  logic [MAP_WORD_W-1:0] rise;
  logic [5:0]            pop_lo;
  logic [5:0]            pop_hi;

  scan_tag_t             tag1_q;
  logic                  carry_q;
  logic [5:0]            pop_lo_q;
  logic [5:0]            pop_hi_q;

  logic [CNT_W-1:0]      acc_q;
  logic [CNT_W-1:0]      det_sum;
  logic [DW-1:0]         det_q;
  logic [15:0]           sum16;

  // Rising edges: set strip whose lower neighbour is clear
  assign prev = tag_i.first ? 1'b0 : carry_q;
  assign rise = word_i & ~{word_i[MAP_WORD_W-2:0], prev};

  always_comb begin
    pop_lo = '0;
    pop_hi = '0;
    for (int i = 0; i < HALF; i++) begin
      pop_lo = pop_lo + 6'(rise[i]);
      pop_hi = pop_hi + 6'(rise[i+HALF]);
    end
  end

  // Stage one registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q  <= '0;
      carry_q <= 1'b0;
    end else begin
      tag1_q <= tag_i;
      if (tag_i.valid) begin
        carry_q <= word_i[MAP_WORD_W-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pop_lo_q <= pop_lo;
    pop_hi_q <= pop_hi;
  end

  // Per-detector running count
  assign det_sum = (tag1_q.first ? '0 : acc_q) + CNT_W'(pop_lo_q) + CNT_W'(pop_hi_q);
  assign sum16   = 16'(det_sum);

  // Stage two: accumulate, report, total up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      det_q   <= '0;
      done_o  <= '0;
      det_o   <= '0;
      count_o <= '0;
      sums_o  <= '0;
    end else if (clear_i) begin
      acc_q   <= '0;
      det_q   <= '0;
      done_o  <= '0;
      sums_o  <= '0;
    end else begin
      done_o.valid <= tag1_q.valid && tag1_q.last;
      done_o.last  <= tag1_q.valid && tag1_q.last && (det_q == DW'(DETECTORS - 1));
      if (tag1_q.valid) begin
        acc_q <= det_sum;
        if (tag1_q.last) begin
          count_o      <= det_sum;
          det_o        <= det_q;
          det_q        <= det_q + DW'(1);
          sums_o.total <= sat_add16(sums_o.total, sum16);
          if (int'(det_q) < PHI_DETS) begin
            sums_o.phi <= sat_add16(sums_o.phi, sum16);
          end else begin
            sums_o.z <= sat_add16(sums_o.z, sum16);
          end
        end
      end
    end
  end

endmodule

@@ rtl/strip_hit_select_and_cluster_count_top.sv @@
// ----------------------------------------------------------------------------
// strip_hit_select_and_cluster_count_top: zero suppression and clustering
// Waveform items: each is accepted in the idle state (map word read), then
//   passes the update state (read-modify-write); input stall is high between.
// End of event: the map is scanned one word a cycle, DETECTORS*ceil(STRIPS/64)
//   words (64 by default), the run counter drains its stage registers, then the
//   min(DETECTORS,16) results go out one per cycle when not stalled.
// Reset: a clearing pass writes zero over all DETECTORS*ceil(STRIPS/64) map
//   words (64 by default) with input stalled; registers reset at once.
// ----------------------------------------------------------------------------
module strip_hit_select_and_cluster_count_top #(
  parameter int DETECTORS = shcc_pkg::DETECTORS_DEF,
  parameter int STRIPS    = shcc_pkg::STRIPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration
  input  logic                            cfg_we_i,
  input  logic [shcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Waveform items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      layer_id_i,
  input  logic [2:0]                      tile_id_i,
  input  logic [7:0]                      strip_id_i,
  input  logic [9:0]                      peak_adc_i,
  input  logic [9:0]                      peak_sample_i,
  input  logic [13:0]                     pedestal_level_i,
  input  logic [13:0]                     noise_rms_i,
  input  logic [63:0]                     event_bco_i,
  input  logic [31:0]                     event_counter_i,
  input  logic                            end_of_event_i,
  // Result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [63:0]                     out_bco_o,
  output logic [31:0]                     out_counter_o,
  output logic [15:0]                     waveforms_total_o,
  output logic [15:0]                     waveforms_signal_o,
  output logic [15:0]                     clusters_total_o,
  output logic [15:0]                     clusters_phi_o,
  output logic [15:0]                     clusters_z_o,
  output logic [3:0]                      detector_index_o,
  output logic [7:0]                      detector_clusters_o,
  output logic                            last_item_o
);
  import shcc_pkg::*;

  localparam int WPD   = (STRIPS + 63) / 64;
  localparam int DEPTH = DETECTORS * WPD;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = (WPD > 1) ? $clog2(WPD) : 1;
  localparam int DW    = $clog2(DETECTORS);
  localparam int CNT_W = $clog2(STRIPS / 2 + 1);
  localparam int NRES  = (DETECTORS > MAX_RESULTS) ? MAX_RESULTS : DETECTORS;
  localparam int IDX_W = $clog2(NRES);

  state_e                state_q, state_d;

  logic [9:0]            window_low_q;
  logic [9:0]            window_high_q;
  logic [7:0]            sigma_multiple_q;

  logic                  in_accept;
  logic                  out_accept;

  hit_flags_t            hit_flags;
  logic [AW-1:0]         hit_addr;
  logic [5:0]            hit_bit;

  hit_flags_t            flags_q;
  logic [AW-1:0]         addr_q;
  logic [5:0]            bit_q;
  logic                  eoe_q;
  logic [63:0]           bco_q;
  logic [31:0]           evcnt_q;
  logic [15:0]           tot_cnt_q;
  logic [15:0]           sig_cnt_q;

  logic [AW-1:0]         scan_addr_q;
  logic [WW-1:0]         scan_wd_q;
  logic                  scan_addr_last;
  logic                  scan_wd_last;
  scan_tag_t             tag_d, tag_q;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MAP_WORD_W-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [MAP_WORD_W-1:0] mem_rdata;

  logic                  cnt_clear;
  cnt_done_t             cnt_done;
  logic [DW-1:0]         cnt_det;
  logic [CNT_W-1:0]      cnt_value;
  cluster_sums_t         sums;

  logic [7:0]            res_q [NRES];
  logic [IDX_W-1:0]      out_idx_q;
  logic                  out_idx_last;

  assign in_accept      = in_valid_i && !in_stall_o;
  assign out_accept     = out_valid_o && !out_stall_i;
  assign scan_addr_last = (scan_addr_q == AW'(DEPTH - 1));
  assign scan_wd_last   = (scan_wd_q == WW'(WPD - 1));
  assign out_idx_last   = (out_idx_q == IDX_W'(NRES - 1));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_low_q     <= WINDOW_LOW_RST;
      window_high_q    <= WINDOW_HIGH_RST;
      sigma_multiple_q <= SIGMA_MULTIPLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_WINDOW_LOW:     window_low_q     <= cfg_wdata_i[9:0];
        CFG_WINDOW_HIGH:    window_high_q    <= cfg_wdata_i[9:0];
        CFG_SIGMA_MULTIPLE: sigma_multiple_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Hit test straight off the input item
  shcc_hit_test #(
    .DETECTORS (DETECTORS),
    .STRIPS    (STRIPS)
  ) u_hit_test (
    .window_low_i     (window_low_q),
    .window_high_i    (window_high_q),
    .sigma_multiple_i (sigma_multiple_q),
    .layer_id_i       (layer_id_i),
    .tile_id_i        (tile_id_i),
    .strip_id_i       (strip_id_i),
    .peak_adc_i       (peak_adc_i),
    .peak_sample_i    (peak_sample_i),
    .pedestal_level_i (pedestal_level_i),
    .noise_rms_i      (noise_rms_i),
    .flags_o          (hit_flags),
    .addr_o           (hit_addr),
    .bit_o            (hit_bit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (scan_addr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_accept) state_d = ST_UPDATE;
      ST_UPDATE: state_d = eoe_q ? ST_SCAN : ST_IDLE;
      ST_SCAN:   if (scan_addr_last) state_d = ST_DRAIN;
      ST_DRAIN:  if (cnt_done.valid && cnt_done.last) state_d = ST_EMIT;
      ST_EMIT:   if (out_accept && out_idx_last) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // State outputs: handshakes, memory ports, scan tag
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = scan_addr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = scan_addr_q;
    cnt_clear   = 1'b0;
    tag_d       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_re     = in_valid_i;
        mem_raddr  = hit_addr;
      end
      ST_UPDATE: begin
        mem_we    = flags_q.signal && flags_q.mapped;
        mem_waddr = addr_q;
        mem_wdata = mem_rdata | ({{(MAP_WORD_W-1){1'b0}}, 1'b1} << bit_q);
        cnt_clear = eoe_q;
      end
      ST_SCAN: begin
        // Read each word and zero it behind the read
        mem_we      = 1'b1;
        mem_re      = 1'b1;
        tag_d.valid = 1'b1;
        tag_d.first = (scan_wd_q == '0);
        tag_d.last  = scan_wd_last;
      end
      ST_DRAIN: ;
      ST_EMIT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // Scan address and word-in-row counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      scan_wd_q   <= '0;
      tag_q       <= '0;
    end else begin
      tag_q <= tag_d;
      if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
        scan_addr_q <= scan_addr_q + AW'(1);
        scan_wd_q   <= scan_wd_last ? '0 : scan_wd_q + WW'(1);
      end else if (state_q == ST_UPDATE) begin
        scan_addr_q <= '0;
        scan_wd_q   <= '0;
      end
    end
  end

  // Accepted item and event counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      eoe_q     <= 1'b0;
      tot_cnt_q <= '0;
      sig_cnt_q <= '0;
    end else if (in_accept) begin
      flags_q   <= hit_flags;
      eoe_q     <= end_of_event_i;
      tot_cnt_q <= sat_add16(tot_cnt_q, 16'd1);
      if (hit_flags.signal) begin
        sig_cnt_q <= sat_add16(sig_cnt_q, 16'd1);
      end
    end else if (out_accept && out_idx_last) begin
      tot_cnt_q <= '0;
      sig_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q <= hit_addr;
      bit_q  <= hit_bit;
      if (end_of_event_i) begin
        bco_q   <= event_bco_i;
        evcnt_q <= event_counter_i;
      end
    end
  end

  // Occupancy map
  shcc_map_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Cluster counting behind the scan
  shcc_run_count #(
    .DETECTORS (DETECTORS),
    .STRIPS    (STRIPS)
  ) u_run_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cnt_clear),
    .tag_i   (tag_q),
    .word_i  (mem_rdata),
    .done_o  (cnt_done),
    .det_o   (cnt_det),
    .count_o (cnt_value),
    .sums_o  (sums)
  );

  // Per-detector results, held at 255
  always_ff @(posedge clk_i) begin
    if (cnt_done.valid && (int'(cnt_det) < NRES)) begin
      res_q[cnt_det[IDX_W-1:0]] <= (int'(cnt_value) > 255) ? 8'hFF : 8'(cnt_value);
    end
  end

  // Result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_idx_q <= '0;
    end else if (out_accept) begin
      out_idx_q <= out_idx_last ? '0 : out_idx_q + IDX_W'(1);
    end
  end

  assign out_bco_o           = bco_q;
  assign out_counter_o       = evcnt_q;
  assign waveforms_total_o   = tot_cnt_q;
  assign waveforms_signal_o  = sig_cnt_q;
  assign clusters_total_o    = sums.total;
  assign clusters_phi_o      = sums.phi;
  assign clusters_z_o        = sums.z;
  assign detector_index_o    = 4'(out_idx_q);
  assign detector_clusters_o = res_q[out_idx_q];
  assign last_item_o         = out_idx_last;

  // Checks
  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_done.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("run counter finished a detector outside the scan");

  a_eoe_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && eoe_q) |=> (state_q == ST_SCAN && scan_addr_q == '0))
    else $error("end of event did not start the scan at word zero");

  a_signal_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_cnt_q <= tot_cnt_q)
    else $error("signal count above waveform count");

  a_event_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && last_item_o) |=> (state_q == ST_IDLE && tot_cnt_q == '0))
    else $error("event not closed after its last result");

  a_no_map_write_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !mem_we)
    else $error("map written while results are out");

endmodule
